// ----- sv/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // parser modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_STR   = 3'd1;
    localparam logic [2:0] MODE_ESC   = 3'd2;
    localparam logic [2:0] MODE_HEX_A = 3'd3;
    localparam logic [2:0] MODE_BS    = 3'd4;
    localparam logic [2:0] MODE_U     = 3'd5;
    localparam logic [2:0] MODE_HEX_B = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_FIN  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_EXP_STR  = 3'd0;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd1;
    localparam logic [2:0] ERR_BAD_U    = 3'd2;
    localparam logic [2:0] ERR_UNP_HIGH = 3'd3;
    localparam logic [2:0] ERR_UNP_LOW  = 3'd4;
    localparam logic [2:0] ERR_CTRL     = 3'd5;
    localparam logic [2:0] ERR_UNTERM   = 3'd6;

    // source characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;

    // surrogate prefixes on code[15:10]
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    localparam int RES_MAX = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] acc;   // hex digits taken so far
        logic [1:0]  cnt;
        logic [9:0]  high;  // high surrogate minus its base
    } t_st;

    typedef struct packed {
        logic [2:0]       cnt;
        logic [1:0]       kind;
        logic [2:0]       code;
        logic [3:0][7:0]  bytes;  // bytes[0] goes out first
    } t_res;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_res utf8_enc(input logic [20:0] cp);
        t_res r;
        r.kind  = KIND_BYTE;
        r.code  = ERR_EXP_STR;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.cnt      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.cnt      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < CP_SUPP_BASE) begin
            r.cnt      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/jsu_if.sv -----
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for source bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       source_end;

    modport source (output valid, output data_byte, output source_end, input ready);
    modport sink   (input valid, input data_byte, input source_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// One step of the unescaper: next parser state and up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  var t_st        i_st,
    input  wire logic [7:0] i_byte,
    input  wire logic      i_end,
    output t_st            o_st,
    output t_res           o_res
);

    t_hex        hx;
    logic [15:0] code;
    logic [20:0] cp_pair;

    assign hx      = hex_digit(i_byte);
    assign code    = {i_st.acc, hx.val};
    assign cp_pair = CP_SUPP_BASE + {1'b0, i_st.high, code[9:0]};

    always_comb begin
        o_st  = i_st;
        o_res = '0;

        case (i_st.mode)
            MODE_STR: begin
                if (i_end) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_UNTERM;
                end else if (i_byte == CH_QUOTE) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_FIN;
                end else if (i_byte == CH_BSL) begin
                    o_st.mode = MODE_ESC;
                end else if (i_byte < CH_SPACE) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_CTRL;
                end else begin
                    o_res.cnt = 3'd1; o_res.bytes[0] = i_byte;
                end
            end
            MODE_ESC: begin
                o_st.mode = MODE_STR;
                o_res.cnt = 3'd1;
                if (i_end) begin
                    o_st = '0;
                    o_res.kind = KIND_ERR; o_res.code = ERR_BAD_ESC;
                end else begin
                    case (i_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: o_res.bytes[0] = i_byte;
                        CH_LO_B: o_res.bytes[0] = CH_BS;
                        CH_LO_F: o_res.bytes[0] = CH_FF;
                        CH_LO_N: o_res.bytes[0] = CH_LF;
                        CH_LO_R: o_res.bytes[0] = CH_CR;
                        CH_LO_T: o_res.bytes[0] = CH_TAB;
                        CH_LO_U: begin
                            o_st.mode = MODE_HEX_A;
                            o_st.acc  = '0;
                            o_st.cnt  = '0;
                            o_res.cnt = 3'd0;
                        end
                        default: begin
                            o_st = '0;
                            o_res.kind = KIND_ERR; o_res.code = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            MODE_HEX_A, MODE_HEX_B: begin
                if (i_end) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR;
                    o_res.code = (i_st.mode == MODE_HEX_A) ? ERR_BAD_U : ERR_UNP_HIGH;
                end else if (!hx.ok) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_BAD_U;
                end else if (i_st.cnt != 2'd3) begin
                    o_st.acc = code[11:0];
                    o_st.cnt = i_st.cnt + 2'd1;
                end else begin
                    o_st.acc = '0;
                    o_st.cnt = '0;
                    if (i_st.mode == MODE_HEX_A) begin
                        if (code[15:10] == SURR_HIGH) begin
                            o_st.high = code[9:0];
                            o_st.mode = MODE_BS;
                        end else if (code[15:10] == SURR_LOW) begin
                            o_st = '0;
                            o_res.cnt = 3'd1; o_res.kind = KIND_ERR;
                            o_res.code = ERR_UNP_LOW;
                        end else begin
                            o_st.mode = MODE_STR;
                            o_res = utf8_enc({5'd0, code});
                        end
                    end else if (code[15:10] != SURR_LOW) begin
                        o_st = '0;
                        o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_UNP_HIGH;
                    end else begin
                        o_st.mode = MODE_STR;
                        o_st.high = '0;
                        o_res = utf8_enc(cp_pair);
                    end
                end
            end
            MODE_BS: begin
                if (i_end || i_byte != CH_BSL) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_UNP_HIGH;
                end else begin
                    o_st.mode = MODE_U;
                end
            end
            MODE_U: begin
                if (i_end || i_byte != CH_LO_U) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_UNP_HIGH;
                end else begin
                    o_st.mode = MODE_HEX_B;
                    o_st.acc  = '0;
                    o_st.cnt  = '0;
                end
            end
            default: begin
                // idle, and any mode code never used
                if (i_end) begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_EXP_STR;
                end else if (i_byte == CH_SPACE || i_byte == CH_TAB ||
                             i_byte == CH_LF || i_byte == CH_CR) begin
                    o_st = i_st;
                end else if (i_byte == CH_QUOTE) begin
                    o_st = '0;
                    o_st.mode = MODE_STR;
                end else begin
                    o_st = '0;
                    o_res.cnt = 3'd1; o_res.kind = KIND_ERR; o_res.code = ERR_EXP_STR;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/jsu_out_buf.sv -----
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register holding the results of one step, sent one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_out_buf
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  var t_res        i_res,
    input  wire logic       i_ready,
    output logic            o_free,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_code,
    output logic            o_last
);

    logic [2:0]      r_left;
    logic [2:0]      n_left;
    logic [1:0]      r_pos;
    logic [1:0]      n_pos;
    logic [3:0][7:0] r_bytes;
    logic [1:0]      r_kind;
    logic [2:0]      r_code;
    logic            xfer;

    assign xfer    = o_valid && i_ready;
    // free when empty, or once the last held result leaves in this cycle
    assign o_free  = (r_left == 3'd0) || (r_left == 3'd1 && i_ready);
    assign o_valid = (r_left != 3'd0);
    assign o_byte  = r_bytes[r_pos];
    assign o_kind  = r_kind;
    assign o_code  = r_code;
    assign o_last  = (r_left == 3'd1);

    always_comb begin
        n_left = r_left;
        n_pos  = r_pos;
        if (i_load) begin
            n_left = i_res.cnt;
            n_pos  = 2'd0;
        end else if (xfer) begin
            n_left = r_left - 3'd1;
            n_pos  = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_pos  <= 2'd0;
        end else begin
            r_left <= n_left;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_kind  <= i_res.kind;
            r_code  <= i_res.code;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(RES_MAX))
        else $error("result count beyond four");

    a_single_non_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_BYTE |-> o_last && o_byte == 8'd0)
        else $error("finish or error result not alone or carries a byte");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("results overwritten before delivery");

endmodule

`default_nettype wire

// ----- sv/json_string_unescape_utf8_unit.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string unescaper producing UTF-8, one source byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one source byte per transfer, or an end-of-source marker
//   (source_end set). o_out carries the results: decoded UTF-8 bytes, then a
//   finish result at the closing quote, or a single error result. The final
//   result caused by an input transfer has last_of_run set; some inputs
//   (blank before a string, opening quote, backslash, most hex digits) cause
//   no result at all. A source byte is taken into the input register, then
//   decoded into the result register once that is free, and its first result
//   is then valid on o_out. Throughput: one input per cycle while each input
//   yields at most one result and o_out does not stall; the result register
//   sends one result per cycle while o_out is ready, so an escape that yields
//   more than one UTF-8 byte holds the input side until its last byte leaves.
//   When o_out stalls, the result register holds and the input register
//   fills, after which i_in.ready drops. Reset empties both registers and puts
//   the parser in idle, waiting for the opening quote.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    jsu_in_if.sink       i_in,
    jsu_out_if.source    o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_st        r_st;
    t_st        n_st;
    t_res       step_res;
    logic       buf_free;
    logic       adv;

    assign adv        = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || adv;

    jsu_decode u_decode (
        .i_st   (r_st),
        .i_byte (r_in_byte),
        .i_end  (r_in_end),
        .o_st   (n_st),
        .o_res  (step_res)
    );

    jsu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (step_res),
        .i_ready (o_out.ready),
        .o_free  (buf_free),
        .o_valid (o_out.valid),
        .o_byte  (o_out.out_byte),
        .o_kind  (o_out.kind),
        .o_code  (o_out.error_code),
        .o_last  (o_out.last_of_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.source_end;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.mode == MODE_IDLE |-> r_st.acc == '0 && r_st.cnt == '0 && r_st.high == '0)
        else $error("idle parser holds stale escape state");

    a_state_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_st))
        else $error("parser state moved without a step");

    a_held_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_end))
        else $error("waiting input lost or changed");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON string unescaper. Source byte streams
// (a directed set, then random strings with escapes, \u code points,
// surrogate pairs and injected faults) go in over valid/ready. A scoreboard
// class predicts every UTF-8 byte, finish and error result and checks each
// output transfer in order. Both sides stall at random, and the result side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int          RANDOM_ITEMS = 200;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          SHOW_MAX     = 10;
    localparam logic [2:0]  NO_ERR       = 3'd0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } t_unesc_result;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       src_end;
    } t_src_item;

    typedef enum int {
        F_NONE, F_IDLE_END, F_IDLE_JUNK, F_STR_END, F_CTRL, F_ESC_LETTER, F_ESC_END,
        F_HEX_BAD, F_HEX_END, F_LOW_ALONE, F_HIGH_JUNK, F_HIGH_NO_U, F_HIGH_NOT_LOW,
        F_HIGH_END, F_HEX2_BAD
    } t_fault;

    // ------------------------------------------------------------------------
    // decoder model and result store
    // ------------------------------------------------------------------------
    class unescape_board;
        logic [2:0]    mode;
        logic [15:0]   hex_acc;
        logic [1:0]    hex_cnt;
        logic [9:0]    high_part;
        t_unesc_result expected_q[$];
        int            n_inputs;
        int            n_results;
        int            n_bytes;
        int            n_finished;
        int            n_errors;
        int            n_fail;
        int            n_shown;
        bit [6:0]      codes_seen;

        function new();
            to_idle();
        endfunction

        static function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void to_idle();
            mode      = MODE_IDLE;
            hex_acc   = '0;
            hex_cnt   = '0;
            high_part = '0;
        endfunction

        function void push(logic [7:0] b, logic [1:0] k, logic [2:0] code);
            t_unesc_result item;
            item = '{out_byte: b, kind: k, error_code: code, last_of_run: 1'b0};
            expected_q.insert(expected_q.size(), item);
        endfunction

        function void fail(logic [2:0] code);
            push(8'h00, KIND_ERR, code);
            to_idle();
        endfunction

        function void push_cp(logic [20:0] cp);
            if (cp < 21'h80) begin
                push(cp[7:0], KIND_BYTE, NO_ERR);
            end else if (cp < 21'h800) begin
                push(8'hC0 | cp[10:6], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[5:0], KIND_BYTE, NO_ERR);
            end else if (cp < 21'h10000) begin
                push(8'hE0 | cp[15:12], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[11:6], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[5:0], KIND_BYTE, NO_ERR);
            end else begin
                push(8'hF0 | cp[20:18], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[17:12], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[11:6], KIND_BYTE, NO_ERR);
                push(8'h80 | cp[5:0], KIND_BYTE, NO_ERR);
            end
        endfunction

        // hex digit of either \u escape
        function void take_digit(logic [7:0] b, bit src_end);
            int          d;
            logic [15:0] code;
            logic [20:0] cp;
            if (src_end) begin
                fail(mode == MODE_HEX_A ? ERR_BAD_U : ERR_UNP_HIGH);
                return;
            end
            d = hex_value(b);
            if (d < 0) begin
                fail(ERR_BAD_U);
                return;
            end
            hex_acc = {hex_acc[11:0], 4'(d)};
            if (hex_cnt < 2'd3) begin
                hex_cnt++;
                return;
            end
            code    = hex_acc;
            hex_acc = '0;
            hex_cnt = '0;
            if (mode == MODE_HEX_A) begin
                if (code >= 16'hD800 && code <= 16'hDBFF) begin
                    high_part = 10'(code - 16'hD800);
                    mode      = MODE_BS;
                end else if (code >= 16'hDC00 && code <= 16'hDFFF) begin
                    fail(ERR_UNP_LOW);
                end else begin
                    mode = MODE_STR;
                    push_cp({5'd0, code});
                end
            end else if (code < 16'hDC00 || code > 16'hDFFF) begin
                fail(ERR_UNP_HIGH);
            end else begin
                mode      = MODE_STR;
                cp        = 21'h10000 + (21'(high_part) << 10) + 21'(code - 16'hDC00);
                high_part = '0;
                push_cp(cp);
            end
        endfunction

        function void note_input(logic [7:0] b, bit src_end);
            int first;
            first = expected_q.size();
            n_inputs++;
            case (mode)
                MODE_STR: begin
                    if (src_end) fail(ERR_UNTERM);
                    else if (b == CH_QUOTE) begin
                        push(8'h00, KIND_FIN, NO_ERR);
                        to_idle();
                    end else if (b == CH_BSL) mode = MODE_ESC;
                    else if (b < CH_SPACE) fail(ERR_CTRL);
                    else push(b, KIND_BYTE, NO_ERR);
                end
                MODE_ESC: begin
                    if (src_end) fail(ERR_BAD_ESC);
                    else begin
                        mode = MODE_STR;
                        case (b)
                            CH_QUOTE, CH_BSL, CH_SLASH: push(b, KIND_BYTE, NO_ERR);
                            CH_LO_B: push(CH_BS, KIND_BYTE, NO_ERR);
                            CH_LO_F: push(CH_FF, KIND_BYTE, NO_ERR);
                            CH_LO_N: push(CH_LF, KIND_BYTE, NO_ERR);
                            CH_LO_R: push(CH_CR, KIND_BYTE, NO_ERR);
                            CH_LO_T: push(CH_TAB, KIND_BYTE, NO_ERR);
                            CH_LO_U: begin
                                mode    = MODE_HEX_A;
                                hex_acc = '0;
                                hex_cnt = '0;
                            end
                            default: fail(ERR_BAD_ESC);
                        endcase
                    end
                end
                MODE_HEX_A, MODE_HEX_B: take_digit(b, src_end);
                MODE_BS: begin
                    if (src_end || b != CH_BSL) fail(ERR_UNP_HIGH);
                    else mode = MODE_U;
                end
                MODE_U: begin
                    if (src_end || b != CH_LO_U) fail(ERR_UNP_HIGH);
                    else begin
                        mode    = MODE_HEX_B;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end
                end
                default: begin
                    if (src_end) fail(ERR_EXP_STR);
                    else if (b == CH_QUOTE) begin
                        to_idle();
                        mode = MODE_STR;
                    end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR)) begin
                        fail(ERR_EXP_STR);
                    end
                end
            endcase
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_result(t_unesc_result got);
            t_unesc_result want;
            n_results++;
            if (expected_q.size() == 0) begin
                n_fail++;
                if (n_shown < SHOW_MAX)
                    $display("unexpected result %0d: byte %02h kind %0d code %0d last %0b",
                             n_results, got.out_byte, got.kind, got.error_code,
                             got.last_of_run);
                n_shown++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
                n_fail++;
                if (n_shown < SHOW_MAX)
                    $display("result %0d: expected %02h/%0d/%0d/%0b got %02h/%0d/%0d/%0b",
                             n_results, want.out_byte, want.kind, want.error_code,
                             want.last_of_run, got.out_byte, got.kind, got.error_code,
                             got.last_of_run);
                n_shown++;
            end
            case (want.kind)
                KIND_BYTE: n_bytes++;
                KIND_FIN:  n_finished++;
                default: begin
                    n_errors++;
                    codes_seen[want.error_code] = 1'b1;
                end
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if();
    jsu_out_if out_if();

    unescape_board board = new();
    t_src_item     src_q[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    json_string_unescape_utf8_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            board.note_input(in_if.data_byte, in_if.source_end);
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result('{out_byte: out_if.out_byte, kind: out_if.kind,
                                 error_code: out_if.error_code,
                                 last_of_run: out_if.last_of_run});
    end

    // ------------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------------
    task automatic add_byte(logic [7:0] b);
        t_src_item item;
        item = '{src_byte: b, src_end: 1'b0};
        src_q.insert(src_q.size(), item);
    endtask

    task automatic add_end();
        t_src_item item;
        item = '{src_byte: 8'($urandom_range(0, 255)), src_end: 1'b1};
        src_q.insert(src_q.size(), item);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + (v - 4'd10);
    endfunction

    task automatic add_u(logic [15:0] v, int n_digits = 4);
        add_byte(CH_BSL);
        add_byte(CH_LO_U);
        for (int k = 3; k > 3 - n_digits; k--)
            add_byte(hex_char(v[k*4 +: 4]));
    endtask

    function automatic bit is_escape_letter(logic [7:0] b);
        case (b)
            CH_QUOTE, CH_BSL, CH_SLASH, CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T,
            CH_LO_U: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_other(logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (unescape_board::hex_value(b) >= 0);
        return b;
    endfunction

    // BMP value outside the surrogate range, spread over the three UTF-8 lengths
    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'h7F));
            1:       return 16'($urandom_range(16'h80, 16'h7FF));
            2:       return 16'($urandom_range(16'h800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
    endfunction

    task automatic add_element();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSL);
                add_byte(b);
            end
            4, 5: begin
                do b = 8'($urandom_range(0, 255));
                while (!is_escape_letter(b) || b == CH_LO_U);
                add_byte(CH_BSL);
                add_byte(b);
            end
            6, 7: add_u(rand_bmp());
            default: begin
                add_u(rand_high());
                add_u(rand_low());
            end
        endcase
    endtask

    task automatic add_fault(t_fault fault);
        logic [7:0]  b;
        logic [15:0] v;
        case (fault)
            F_STR_END: add_end();
            F_CTRL:    add_byte(8'($urandom_range(0, 8'h1F)));
            F_ESC_LETTER: begin
                do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
                add_byte(CH_BSL);
                add_byte(b);
            end
            F_ESC_END: begin
                add_byte(CH_BSL);
                add_end();
            end
            F_HEX_BAD: begin
                add_u(rand_bmp(), $urandom_range(0, 3));
                add_byte(rand_non_hex());
            end
            F_HEX_END: begin
                add_u(rand_bmp(), $urandom_range(0, 3));
                add_end();
            end
            F_LOW_ALONE: add_u(rand_low());
            F_HIGH_JUNK: begin
                add_u(rand_high());
                if ($urandom_range(0, 3) == 0) add_end();
                else add_byte(rand_other(CH_BSL));
            end
            F_HIGH_NO_U: begin
                add_u(rand_high());
                add_byte(CH_BSL);
                if ($urandom_range(0, 3) == 0) add_end();
                else add_byte(rand_other(CH_LO_U));
            end
            F_HIGH_NOT_LOW: begin
                add_u(rand_high());
                do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
                add_u(v);
            end
            F_HIGH_END: begin
                add_u(rand_high());
                add_u(rand_low(), $urandom_range(0, 3));
                add_end();
            end
            default: begin
                // bad digit inside the second escape
                add_u(rand_high());
                add_u(rand_low(), $urandom_range(0, 3));
                add_byte(rand_non_hex());
            end
        endcase
    endtask

    // one string; about a quarter carry a fault, after which the string stops
    task automatic add_string();
        int         n_elem;
        int         fault_at;
        t_fault     fault;
        logic [7:0] b;
        n_elem   = $urandom_range(0, 6);
        fault_at = $urandom_range(0, n_elem);
        fault    = ($urandom_range(0, 99) < 25) ? t_fault'($urandom_range(1, F_HEX2_BAD)) : F_NONE;
        repeat ($urandom_range(0, 2)) add_byte(rand_blank());
        if (fault == F_IDLE_END) begin
            add_end();
            return;
        end
        if (fault == F_IDLE_JUNK) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR);
            add_byte(b);
            return;
        end
        add_byte(CH_QUOTE);
        for (int i = 0; i <= n_elem; i++) begin
            if (fault != F_NONE && i == fault_at) begin
                add_fault(fault);
                return;
            end
            if (i < n_elem) add_element();
        end
        add_byte(CH_QUOTE);
    endtask

    task automatic build_directed();
        add_end();                              // end of source while idle
        add_byte(8'hFF);                        // stray byte while idle
        add_byte(CH_CR);
        add_byte(CH_QUOTE);
        add_byte(8'hFF);                        // high bytes pass through
        add_byte(8'h80);
        add_byte(8'h00);                        // raw control byte
        add_byte(CH_QUOTE);
        add_byte(CH_BSL);
        add_byte("q");                          // unknown escape letter
        add_byte(CH_QUOTE);
        add_byte(CH_BSL);
        add_end();                              // end right after a backslash
        add_byte(CH_QUOTE);
        add_end();                              // unterminated
        add_byte(CH_LF);
        add_byte(CH_QUOTE);
        add_byte(CH_BSL);
        add_byte(CH_LO_U);
        add_byte("F");
        add_byte("f");
        add_byte("F");
        add_byte("f");
        add_byte(CH_QUOTE);
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic drive_source();
        int gap;
        foreach (src_q[i]) begin
            // every third stretch of 32 transfers runs back to back
            gap = ((i / 32) % 3 == 2) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid      = 1'b1;
            in_if.data_byte  = src_q[i].src_byte;
            in_if.source_end = src_q[i].src_end;
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        in_if.valid = 1'b0;
    endtask

    initial begin : result_sink
        int wait_cycles;
        bit held;
        held         = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            // one long hold-off while the source keeps offering
            if (!held && board.n_results >= 40) begin
                held         = 1'b1;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            wait_cycles = ((board.n_results / 24) % 3 == 1) ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0) begin
                out_if.ready = 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : main_seq
        int n_directed;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.source_end = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        build_directed();
        n_directed = src_q.size();
        while (src_q.size() < n_directed + RANDOM_ITEMS) add_string();
        drive_source();

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d source transfers and %0d results: %0d bytes, %0d strings closed",
                 board.n_inputs, board.n_results, board.n_bytes, board.n_finished);
        $display("%0d error results over %0d of 7 error codes, %0d mismatches",
                 board.n_errors, $countones(board.codes_seen), board.n_fail);
        if (board.n_fail == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
